/* hdl/spd_pkg.sv */
`timescale 1ns / 1ps
package spd_pkg;

  localparam int WIN_LEN   = 20;
  localparam int WIN_AW    = 5;
  localparam int NUM_CLIFF = 4;
  localparam int CFG_AW    = 5;

  // frame markers
  localparam logic [7:0] START_BYTE = 8'd19;
  localparam logic [7:0] LEN_BYTE   = 8'(WIN_LEN - 3);
  localparam logic [7:0] ID_CL      = 8'd28;
  localparam logic [7:0] ID_CFL     = 8'd29;
  localparam logic [7:0] ID_CFR     = 8'd30;
  localparam logic [7:0] ID_CR      = 8'd31;
  localparam logic [7:0] ID_DIST    = 8'd19;
  localparam logic [7:0] ID_IR      = 8'd17;

  // byte offsets within the window
  localparam logic [WIN_AW-1:0] OFF_START  = 5'd0;
  localparam logic [WIN_AW-1:0] OFF_LEN    = 5'd1;
  localparam logic [WIN_AW-1:0] OFF_ID_CL  = 5'd2;
  localparam logic [WIN_AW-1:0] OFF_CL_HI  = 5'd3;
  localparam logic [WIN_AW-1:0] OFF_CL_LO  = 5'd4;
  localparam logic [WIN_AW-1:0] OFF_ID_CFL = 5'd5;
  localparam logic [WIN_AW-1:0] OFF_CFL_HI = 5'd6;
  localparam logic [WIN_AW-1:0] OFF_CFL_LO = 5'd7;
  localparam logic [WIN_AW-1:0] OFF_ID_CFR = 5'd8;
  localparam logic [WIN_AW-1:0] OFF_CFR_HI = 5'd9;
  localparam logic [WIN_AW-1:0] OFF_CFR_LO = 5'd10;
  localparam logic [WIN_AW-1:0] OFF_ID_CR  = 5'd11;
  localparam logic [WIN_AW-1:0] OFF_CR_HI  = 5'd12;
  localparam logic [WIN_AW-1:0] OFF_CR_LO  = 5'd13;
  localparam logic [WIN_AW-1:0] OFF_ID_DST = 5'd14;
  localparam logic [WIN_AW-1:0] OFF_DST_HI = 5'd15;
  localparam logic [WIN_AW-1:0] OFF_DST_LO = 5'd16;
  localparam logic [WIN_AW-1:0] OFF_ID_IR  = 5'd17;
  localparam logic [WIN_AW-1:0] OFF_IR     = 5'd18;
  localparam logic [WIN_AW-1:0] OFF_LAST   = 5'(WIN_LEN - 1);

  localparam logic [1:0] ACT_FWD = 2'd0;
  localparam logic [1:0] ACT_BWD = 2'd3;

  typedef enum logic [2:0] {
    REG_THR_L   = 3'd0,
    REG_THR_FL  = 3'd1,
    REG_THR_FR  = 3'd2,
    REG_THR_R   = 3'd3,
    REG_POL     = 3'd4
  } spd_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LEVEL,
    ST_EMIT
  } spd_state_t;

  typedef struct packed {
    logic [NUM_CLIFF-1:0][15:0] thr;
    logic                       high_pol;
  } spd_cfg_t;

  typedef struct packed {
    logic              push;
    logic [7:0]        data;
    logic              rd_en;
    logic [WIN_AW-1:0] rd_off;
    logic              slide;
    logic              clear;
  } spd_win_cmd_t;

  typedef struct packed {
    logic       fill_last;
    logic [7:0] rd_data;
  } spd_win_sts_t;

  function automatic logic [WIN_AW-1:0] spd_wrap(logic [WIN_AW:0] s);
    logic [WIN_AW:0] t;
    t = s - (WIN_AW+1)'(WIN_LEN);
    return (s >= (WIN_AW+1)'(WIN_LEN)) ? t[WIN_AW-1:0] : s[WIN_AW-1:0];
  endfunction

  function automatic logic spd_byte_ok(logic [WIN_AW-1:0] off, logic [7:0] b);
    logic ok;
    ok = 1'b1;
    unique case (off)
      OFF_START:  ok = (b == START_BYTE);
      OFF_LEN:    ok = (b == LEN_BYTE);
      OFF_ID_CL:  ok = (b == ID_CL);
      OFF_ID_CFL: ok = (b == ID_CFL);
      OFF_ID_CFR: ok = (b == ID_CFR);
      OFF_ID_CR:  ok = (b == ID_CR);
      OFF_ID_DST: ok = (b == ID_DIST);
      OFF_ID_IR:  ok = (b == ID_IR);
      default:    ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

/* hdl/spd_in_if.sv */
`timescale 1ns / 1ps
interface spd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [1:0] motion_action;

  modport source (output valid, rx_byte, motion_action, input ready);
  modport sink   (input valid, rx_byte, motion_action, output ready);
endinterface

/* hdl/spd_out_if.sv */
`timescale 1ns / 1ps
interface spd_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic [15:0]        cliff_left;
  logic [15:0]        cliff_front_left;
  logic [15:0]        cliff_front_right;
  logic [15:0]        cliff_right;
  logic [3:0]         cliff_bits;
  logic signed [15:0] distance;
  logic [7:0]         ir_code;
  logic               stop_motion;
  logic [2:0]         led_bits;
  logic [31:0]        packet_index;

  modport source (output valid, status, cliff_left, cliff_front_left, cliff_front_right,
                  cliff_right, cliff_bits, distance, ir_code, stop_motion, led_bits,
                  packet_index, input ready);
  modport sink   (input valid, status, cliff_left, cliff_front_left, cliff_front_right,
                  cliff_right, cliff_bits, distance, ir_code, stop_motion, led_bits,
                  packet_index, output ready);
endinterface

/* hdl/spd_cfg_regs.sv */
`timescale 1ns / 1ps
module spd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output spd_pkg::spd_cfg_t          cfg
);
  import spd_pkg::*;

  spd_cfg_t cfg_r;
  spd_cfg_t cfg_nxt;
  spd_reg_t idx;
  logic     wr;

  assign idx = spd_reg_t'(paddr[CFG_AW-1:2]);
  assign wr  = psel & penable & pwrite;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_THR_L:  cfg_nxt.thr[0]   = pwdata[15:0];
        REG_THR_FL: cfg_nxt.thr[1]   = pwdata[15:0];
        REG_THR_FR: cfg_nxt.thr[2]   = pwdata[15:0];
        REG_THR_R:  cfg_nxt.thr[3]   = pwdata[15:0];
        REG_POL:    cfg_nxt.high_pol = pwdata[0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THR_L:  prdata = {16'd0, cfg_r.thr[0]};
      REG_THR_FL: prdata = {16'd0, cfg_r.thr[1]};
      REG_THR_FR: prdata = {16'd0, cfg_r.thr[2]};
      REG_THR_R:  prdata = {16'd0, cfg_r.thr[3]};
      REG_POL:    prdata = {31'd0, cfg_r.high_pol};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr      <= '0;
      cfg_r.high_pol <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hdl/spd_window.sv */
`timescale 1ns / 1ps
module spd_window (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spd_pkg::spd_win_cmd_t cmd,
  output spd_pkg::spd_win_sts_t sts
);
  import spd_pkg::*;

  // circular buffer: base_r is the oldest byte, a slide just moves it on
  logic [7:0]        mem [WIN_LEN];
  logic [WIN_AW-1:0] base_r, base_nxt;
  logic [WIN_AW-1:0] fill_r, fill_nxt;
  logic [WIN_AW-1:0] wr_addr;
  logic [WIN_AW-1:0] rd_addr;
  logic [7:0]        rd_data_r;

  assign wr_addr = spd_wrap({1'b0, base_r} + {1'b0, fill_r});
  assign rd_addr = spd_wrap({1'b0, base_r} + {1'b0, cmd.rd_off});

  assign sts.fill_last = (fill_r == OFF_LAST);
  assign sts.rd_data   = rd_data_r;

  always_comb begin
    base_nxt = base_r;
    fill_nxt = fill_r;
    if (cmd.push) begin
      fill_nxt = fill_r + 1'b1;
    end else if (cmd.slide) begin
      base_nxt = spd_wrap({1'b0, base_r} + (WIN_AW+1)'(1));
      fill_nxt = OFF_LAST;
    end else if (cmd.clear) begin
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      fill_r <= '0;
    end else begin
      base_r <= base_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= cmd.data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

/* hdl/spd_engine.sv */
`timescale 1ns / 1ps
module spd_engine #(
  parameter int SEQUENCE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  spd_in_if.sink                in_ch,
  spd_out_if.source             out_ch,
  input  spd_pkg::spd_cfg_t     cfg,
  output spd_pkg::spd_win_cmd_t win_cmd,
  input  spd_pkg::spd_win_sts_t win_sts
);
  import spd_pkg::*;

  spd_state_t state_r, state_nxt;

  logic [WIN_AW-1:0]         k_r;
  logic                      proc_v_r;
  logic [WIN_AW-1:0]         proc_off_r;
  logic [7:0]                sum_r;
  logic                      ok_r;
  logic                      pass_r;
  logic [1:0]                j_r;
  logic [NUM_CLIFF-1:0]      lvl_r;
  logic [1:0]                act_r;
  logic [NUM_CLIFF-1:0][15:0] cliff_r;
  logic [15:0]               dist_r;
  logic [7:0]                ir_r;
  logic [SEQUENCE_WIDTH-1:0] cnt_r;

  logic                      out_valid_r;
  logic                      out_status_r;
  logic [NUM_CLIFF-1:0][15:0] out_cliff_r;
  logic [3:0]                out_bits_r;
  logic [15:0]               out_dist_r;
  logic [7:0]                out_ir_r;
  logic                      out_stop_r;
  logic [2:0]                out_led_r;
  logic [31:0]               out_idx_r;

  logic       scan_start;
  logic       scan_last;
  logic       emit;
  logic [7:0] sum_cur;
  logic       ok_cur;
  logic       frame_pass;
  logic       front;
  logic       side;
  logic       stop;

  // shared byte unit: one add and one marker compare per window byte
  assign sum_cur    = sum_r + win_sts.rd_data;
  assign ok_cur     = ok_r & spd_byte_ok(proc_off_r, win_sts.rd_data);
  assign frame_pass = ok_cur && (sum_cur == 8'd0);
  assign scan_last  = proc_v_r && (proc_off_r == OFF_LAST);

  assign front = lvl_r[1] | lvl_r[2];
  assign side  = lvl_r[0] | lvl_r[3];
  assign stop  = ((act_r == ACT_FWD) && front) || ((act_r == ACT_BWD) && side);

  always_comb begin
    state_nxt      = state_r;
    in_ch.ready    = 1'b0;
    scan_start     = 1'b0;
    emit           = 1'b0;
    win_cmd        = '0;
    win_cmd.data   = in_ch.rx_byte;
    win_cmd.rd_off = k_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          win_cmd.push = 1'b1;
          if (win_sts.fill_last) begin
            scan_start = 1'b1;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        win_cmd.rd_en = (k_r <= OFF_LAST);
        if (scan_last) begin
          state_nxt = frame_pass ? ST_LEVEL : ST_EMIT;
        end
      end
      ST_LEVEL: begin
        if (j_r == 2'(NUM_CLIFF - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          emit          = 1'b1;
          win_cmd.slide = !pass_r;
          win_cmd.clear = pass_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      proc_v_r    <= 1'b0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r  <= state_nxt;
      proc_v_r <= win_cmd.rd_en;
      if (scan_start) begin
        k_r <= '0;
      end else if (win_cmd.rd_en) begin
        k_r <= k_r + 1'b1;
      end
      if (state_r == ST_LEVEL) begin
        j_r <= j_r + 1'b1;
      end else begin
        j_r <= '0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (emit && pass_r) begin
        cnt_r <= cnt_r + SEQUENCE_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      act_r <= in_ch.motion_action;
    end
    if (scan_start) begin
      sum_r <= 8'd0;
      ok_r  <= 1'b1;
    end else if (proc_v_r) begin
      sum_r <= sum_cur;
      ok_r  <= ok_cur;
    end
    if (win_cmd.rd_en) begin
      proc_off_r <= k_r;
    end
    if (scan_last) begin
      pass_r <= frame_pass;
    end
    if (proc_v_r) begin
      case (proc_off_r)
        OFF_CL_HI:  cliff_r[0][15:8] <= win_sts.rd_data;
        OFF_CL_LO:  cliff_r[0][7:0]  <= win_sts.rd_data;
        OFF_CFL_HI: cliff_r[1][15:8] <= win_sts.rd_data;
        OFF_CFL_LO: cliff_r[1][7:0]  <= win_sts.rd_data;
        OFF_CFR_HI: cliff_r[2][15:8] <= win_sts.rd_data;
        OFF_CFR_LO: cliff_r[2][7:0]  <= win_sts.rd_data;
        OFF_CR_HI:  cliff_r[3][15:8] <= win_sts.rd_data;
        OFF_CR_LO:  cliff_r[3][7:0]  <= win_sts.rd_data;
        OFF_DST_HI: dist_r[15:8]     <= win_sts.rd_data;
        OFF_DST_LO: dist_r[7:0]      <= win_sts.rd_data;
        OFF_IR:     ir_r             <= win_sts.rd_data;
        default: ;
      endcase
    end
    // one comparator, stepped over the four readings
    if (state_r == ST_LEVEL) begin
      lvl_r[j_r] <= (cliff_r[j_r] > cfg.thr[j_r]) ? cfg.high_pol : ~cfg.high_pol;
    end
    if (emit) begin
      out_status_r <= !pass_r;
      if (pass_r) begin
        out_cliff_r <= cliff_r;
        out_bits_r  <= {lvl_r[0], lvl_r[1], lvl_r[2], lvl_r[3]};
        out_dist_r  <= dist_r;
        out_ir_r    <= ir_r;
        out_stop_r  <= stop;
        out_led_r   <= {lvl_r[0], front, lvl_r[3]};
        out_idx_r   <= 32'(cnt_r);
      end else begin
        out_cliff_r <= '0;
        out_bits_r  <= '0;
        out_dist_r  <= '0;
        out_ir_r    <= '0;
        out_stop_r  <= 1'b0;
        out_led_r   <= '0;
        out_idx_r   <= '0;
      end
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.cliff_left        = out_cliff_r[0];
  assign out_ch.cliff_front_left  = out_cliff_r[1];
  assign out_ch.cliff_front_right = out_cliff_r[2];
  assign out_ch.cliff_right       = out_cliff_r[3];
  assign out_ch.cliff_bits        = out_bits_r;
  assign out_ch.distance          = $signed(out_dist_r);
  assign out_ch.ir_code           = out_ir_r;
  assign out_ch.stop_motion       = out_stop_r;
  assign out_ch.led_bits          = out_led_r;
  assign out_ch.packet_index      = out_idx_r;

endmodule

/* hdl/sensor_packet_deframer.sv */
`timescale 1ns / 1ps
// Sensor packet deframer. Serial bytes enter one per beat on in_ch into a 20-byte window;
// a beat that does not fill the window gives no result. The beat that fills it starts a
// walk over the window memory, one byte per cycle through a single read port into one
// shared add-and-compare unit that checks the markers and the byte sum and picks out the
// fields, then, for a good frame only, one threshold comparator stepped over the four
// cliff readings, and then the result register is loaded, raising out_ch.valid; the load
// waits while an earlier result is still held. in_ch.ready is low from that beat until the
// load. A good frame gives status 0 with the decoded fields and advances the packet
// counter; a bad one gives status 1 with all other fields zero and drops the oldest byte.
// Registers (APB, byte address 4*i): 0..3 cliff thresholds left, front left, front right,
// right (16 bits, reset 0); 4 high polarity (1 bit, reset 1). Write them only while the
// block is idle.
module sensor_packet_deframer #(
  parameter int SEQUENCE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  spd_in_if.sink                     in_ch,
  spd_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import spd_pkg::*;

  spd_cfg_t     cfg;
  spd_win_cmd_t win_cmd;
  spd_win_sts_t win_sts;

  assign pready = 1'b1;

  spd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  spd_window u_win (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (win_cmd),
    .sts   (win_sts)
  );

  spd_engine #(
    .SEQUENCE_WIDTH (SEQUENCE_WIDTH)
  ) u_eng (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg     (cfg),
    .win_cmd (win_cmd),
    .win_sts (win_sts)
  );

endmodule

/* hdl/spd_checker.sv */
`timescale 1ns / 1ps
module spd_sva (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        status,
  input logic [15:0] cliff_left,
  input logic [15:0] cliff_right,
  input logic [3:0]  cliff_bits,
  input logic [15:0] distance,
  input logic        stop_motion,
  input logic [2:0]  led_bits,
  input logic [31:0] packet_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_misalign_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status |-> cliff_left == 16'd0 && cliff_right == 16'd0 &&
      cliff_bits == 4'd0 && distance == 16'd0 && !stop_motion &&
      led_bits == 3'd0 && packet_index == 32'd0)
    else $error("misaligned result carries data");

  a_led_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !status |->
      led_bits == {cliff_bits[3], cliff_bits[2] | cliff_bits[1], cliff_bits[0]})
    else $error("led bits disagree with cliff bits");

  a_stop_needs_cliff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && stop_motion |-> !status && cliff_bits != 4'd0)
    else $error("stop raised without a detected cliff");

endmodule

bind sensor_packet_deframer spd_sva u_spd_sva (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .cliff_left   (out_ch.cliff_left),
  .cliff_right  (out_ch.cliff_right),
  .cliff_bits   (out_ch.cliff_bits),
  .distance     (out_ch.distance),
  .stop_motion  (out_ch.stop_motion),
  .led_bits     (out_ch.led_bits),
  .packet_index (out_ch.packet_index)
);

/* tb/sv/spd_checker.sv */
`timescale 1ns / 1ps
module spd_checker #(
  parameter int SEQ_W = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  spd_in_if                          in_ch,
  spd_out_if                         out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic [31:0]                prdata,
  input  logic                       pready,
  output int                         mismatch_count,
  output int                         frames_due
);
  import spd_pkg::*;

  typedef struct packed {
    logic               status;
    logic [15:0]        cl;
    logic [15:0]        cfl;
    logic [15:0]        cfr;
    logic [15:0]        cr;
    logic [3:0]         bits;
    logic signed [15:0] dst;
    logic [7:0]         ir;
    logic               stop;
    logic [2:0]         led;
    logic [31:0]        idx;
  } frame_t;

  logic [7:0]       win [WIN_LEN];
  int               fill;
  logic [SEQ_W-1:0] frames_decoded;
  logic [15:0]      thr [NUM_CLIFF];
  logic             pol;
  frame_t           expected_frames [$];
  int               errs = 0;

  assign mismatch_count = errs;
  assign frames_due     = expected_frames.size();

  task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    errs++;
    if (errs <= 10)
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, exp_v, got_v);
  endtask

  task automatic check_field(string what, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) note_mismatch(what, exp_v, got_v);
  endtask

  function automatic logic [15:0] word_at(int at);
    return {win[at], win[at+1]};
  endfunction

  function automatic logic level(logic [15:0] reading, logic [15:0] lim);
    return (reading > lim) ? pol : ~pol;
  endfunction

  function automatic bit frame_good();
    logic [7:0] sum;
    sum = '0;
    if (win[OFF_START] != START_BYTE || win[OFF_LEN] != LEN_BYTE ||
        win[OFF_ID_CL] != ID_CL || win[OFF_ID_CFL] != ID_CFL ||
        win[OFF_ID_CFR] != ID_CFR || win[OFF_ID_CR] != ID_CR ||
        win[OFF_ID_DST] != ID_DIST || win[OFF_ID_IR] != ID_IR)
      return 1'b0;
    foreach (win[k]) sum += win[k];
    return sum == 8'h00;
  endfunction

  function automatic logic [31:0] reg_value(spd_reg_t r);
    case (r) inside
      REG_THR_L, REG_THR_FL, REG_THR_FR, REG_THR_R: return {16'h0, thr[r]};
      REG_POL: return {31'h0, pol};
      default: return '0;
    endcase
  endfunction

  task automatic absorb_byte(logic [7:0] b, logic [1:0] act);
    frame_t     f;
    logic [3:0] bits;
    logic       front;
    if (fill >= WIN_LEN) fill = WIN_LEN - 1;
    win[fill] = b;
    fill++;
    if (fill < WIN_LEN) return;
    f = '0;
    if (!frame_good()) begin
      // misaligned: drop the oldest byte, window stays one short of full
      for (int k = 0; k < WIN_LEN - 1; k++) win[k] = win[k+1];
      fill = WIN_LEN - 1;
      f.status = 1'b1;
      expected_frames.push_back(f);
      return;
    end
    f.cl   = word_at(OFF_CL_HI);
    f.cfl  = word_at(OFF_CFL_HI);
    f.cfr  = word_at(OFF_CFR_HI);
    f.cr   = word_at(OFF_CR_HI);
    bits   = {level(f.cl, thr[REG_THR_L]), level(f.cfl, thr[REG_THR_FL]),
              level(f.cfr, thr[REG_THR_FR]), level(f.cr, thr[REG_THR_R])};
    front  = bits[2] | bits[1];
    f.bits = bits;
    f.dst  = word_at(OFF_DST_HI);
    f.ir   = win[OFF_IR];
    f.stop = (act == ACT_FWD && front) || (act == ACT_BWD && (bits[3] | bits[0]));
    f.led  = {bits[3], front, bits[0]};
    f.idx  = 32'(frames_decoded);
    frames_decoded++;
    fill = 0;
    expected_frames.push_back(f);
  endtask

  task automatic compare_frame(frame_t e);
    check_field("status", e.status, out_ch.status);
    check_field("cliff_left", e.cl, out_ch.cliff_left);
    check_field("cliff_front_left", e.cfl, out_ch.cliff_front_left);
    check_field("cliff_front_right", e.cfr, out_ch.cliff_front_right);
    check_field("cliff_right", e.cr, out_ch.cliff_right);
    check_field("cliff_bits", e.bits, out_ch.cliff_bits);
    check_field("distance", e.dst, out_ch.distance);
    check_field("ir_code", e.ir, out_ch.ir_code);
    check_field("stop_motion", e.stop, out_ch.stop_motion);
    check_field("led_bits", e.led, out_ch.led_bits);
    check_field("packet_index", e.idx, out_ch.packet_index);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill           = 0;
      frames_decoded = '0;
      foreach (thr[i]) thr[i] = '0;
      pol = 1'b1;
      expected_frames.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (spd_reg_t'(paddr[CFG_AW-1:2]))
            REG_THR_L:  thr[REG_THR_L]  = pwdata[15:0];
            REG_THR_FL: thr[REG_THR_FL] = pwdata[15:0];
            REG_THR_FR: thr[REG_THR_FR] = pwdata[15:0];
            REG_THR_R:  thr[REG_THR_R]  = pwdata[15:0];
            REG_POL:    pol             = pwdata[0];
            default: ;
          endcase
        end else begin
          check_field("register readback", reg_value(spd_reg_t'(paddr[CFG_AW-1:2])), prdata);
        end
      end
      if (in_ch.valid && in_ch.ready) absorb_byte(in_ch.rx_byte, in_ch.motion_action);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_frames.size() == 0)
          note_mismatch("unexpected result beat, status", '0, out_ch.status);
        else
          compare_frame(expected_frames.pop_front());
      end
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import spd_pkg::*;

  localparam int ITEM_GOAL = 1550;
  localparam int PHASES    = 8;
  localparam int SETTLE    = 40;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                mismatches;
  int                frames_due;
  int                bytes_sent    = 0;
  int                send_idle_pct = 0;
  int                stall_pct     = 0;
  logic [15:0]       thr_now  [NUM_CLIFF];
  logic [7:0]        frame_buf [WIN_LEN];

  spd_in_if  in_ch ();
  spd_out_if out_ch ();

  sensor_packet_deframer uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  spd_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .mismatch_count (mismatches),
    .frames_due     (frames_due)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  task automatic send_byte(logic [7:0] b, logic [1:0] act);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.rx_byte       <= b;
    in_ch.motion_action <= act;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic apb_access(spd_reg_t r, logic wr, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(int p);
    logic pol;
    case (p)
      0: begin thr_now = '{default: 16'h0000}; pol = 1'b1; end
      1: begin thr_now = '{default: 16'hFFFF}; pol = 1'b0; end
      2: begin thr_now = '{default: 16'h0000}; pol = 1'b0; end
      3: begin thr_now = '{default: 16'hFFFF}; pol = 1'b1; end
      default: begin
        foreach (thr_now[i]) thr_now[i] = 16'($urandom);
        pol = 1'($urandom);
      end
    endcase
    apb_access(REG_THR_L, 1'b1, {16'h0, thr_now[REG_THR_L]});
    apb_access(REG_THR_FL, 1'b1, {16'h0, thr_now[REG_THR_FL]});
    apb_access(REG_THR_FR, 1'b1, {16'h0, thr_now[REG_THR_FR]});
    apb_access(REG_THR_R, 1'b1, {16'h0, thr_now[REG_THR_R]});
    apb_access(REG_POL, 1'b1, {31'h0, pol});
    apb_access(REG_THR_L, 1'b0, '0);
    apb_access(REG_THR_FL, 1'b0, '0);
    apb_access(REG_THR_FR, 1'b0, '0);
    apb_access(REG_THR_R, 1'b0, '0);
    apb_access(REG_POL, 1'b0, '0);
  endtask

  // well-formed frame; last byte balances the sum to zero
  function automatic void build_frame(logic [15:0] cl, logic [15:0] cfl, logic [15:0] cfr,
                                      logic [15:0] cr, logic [15:0] dst, logic [7:0] ir);
    logic [7:0] sum;
    frame_buf[OFF_START]  = START_BYTE;
    frame_buf[OFF_LEN]    = LEN_BYTE;
    frame_buf[OFF_ID_CL]  = ID_CL;
    frame_buf[OFF_CL_HI]  = cl[15:8];
    frame_buf[OFF_CL_LO]  = cl[7:0];
    frame_buf[OFF_ID_CFL] = ID_CFL;
    frame_buf[OFF_CFL_HI] = cfl[15:8];
    frame_buf[OFF_CFL_LO] = cfl[7:0];
    frame_buf[OFF_ID_CFR] = ID_CFR;
    frame_buf[OFF_CFR_HI] = cfr[15:8];
    frame_buf[OFF_CFR_LO] = cfr[7:0];
    frame_buf[OFF_ID_CR]  = ID_CR;
    frame_buf[OFF_CR_HI]  = cr[15:8];
    frame_buf[OFF_CR_LO]  = cr[7:0];
    frame_buf[OFF_ID_DST] = ID_DIST;
    frame_buf[OFF_DST_HI] = dst[15:8];
    frame_buf[OFF_DST_LO] = dst[7:0];
    frame_buf[OFF_ID_IR]  = ID_IR;
    frame_buf[OFF_IR]     = ir;
    sum = '0;
    for (int k = 0; k < WIN_LEN - 1; k++) sum += frame_buf[k];
    frame_buf[OFF_LAST] = -sum;
  endfunction

  // readings clustered on the threshold edges so both bit values turn up
  function automatic logic [15:0] pick_reading(logic [15:0] lim);
    case ($urandom_range(5))
      0: return lim;
      1: return lim + 16'd1;
      2: return lim - 16'd1;
      3: return 16'h0000;
      4: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind >= 88) begin
      n = $urandom_range(1, 25);
      repeat (n)
        send_byte(($urandom_range(3) == 0) ? START_BYTE : 8'($urandom), 2'($urandom));
      return;
    end
    build_frame(pick_reading(thr_now[REG_THR_L]), pick_reading(thr_now[REG_THR_FL]),
                pick_reading(thr_now[REG_THR_FR]), pick_reading(thr_now[REG_THR_R]),
                16'($urandom), 8'($urandom));
    if (kind >= 70 && kind < 80)
      frame_buf[$urandom_range(WIN_LEN - 1)] ^= 8'($urandom_range(1, 255));
    n = (kind >= 80) ? $urandom_range(1, WIN_LEN - 1) : WIN_LEN;
    for (int k = 0; k < n; k++) send_byte(frame_buf[k], 2'($urandom));
  endtask

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (frames_due != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.rx_byte       <= '0;
    in_ch.motion_action <= ACT_FWD;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      set_config(p);
      if (p == 0) begin
        // extreme and mid-scale readings, most negative distance, forward over a cliff
        build_frame(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 8'hFF);
        for (int k = 0; k < WIN_LEN - 1; k++) send_byte(frame_buf[k], ACT_BWD);
        send_byte(frame_buf[OFF_LAST], ACT_FWD);
        // partial window: no result until it fills
        send_byte(8'h00, ACT_BWD);
        send_byte(8'hFF, ACT_FWD);
        send_byte(8'h55, 2'($urandom));
        send_byte(8'hAA, 2'($urandom));
        send_byte(START_BYTE, 2'($urandom));
      end
      while (bytes_sent < (p + 1) * ITEM_GOAL / PHASES) send_frame();
      wait_quiet();
    end
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
